### rtl/rmv_pkg.sv
package rmv_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 16;
   localparam int COUNT_BITS  = 32;
   localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
   localparam int MAG_BITS    = MEAN_BITS + 1;
   localparam int SUMSQ_BITS  = 64;
   localparam int OPND_BITS   = 64;
   localparam int ACC_BITS    = OPND_BITS + COUNT_BITS;
   localparam int STEP_BITS   = 7;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [0:0] {
      UOP_MUL,
      UOP_DIV
   } unit_op_type;

   typedef struct packed {
      logic                 start;
      unit_op_type          op;
      logic [STEP_BITS-1:0] steps;
   } unit_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_SQUARE,
      ST_SCALE,
      ST_TERM,
      ST_VAR,
      ST_DONE
   } state_type;

endpackage

### rtl/running_mean_variance.sv
// Welford running mean and variance of signed 24-bit samples. Each beat on
// the request side yields one response beat with the updated sample count,
// the mean in signed Q24.16 and the sample variance in unsigned Q48.16;
// the overflow flag is set when the sum of squares saturated, the mean was
// clamped or the sample was dropped because the count is already at its
// maximum. All multiplications and divisions run through one shared
// shift-add/subtract unit that retires one bit per cycle: the mean division
// (41 steps), the squaring (41), the scaling by count minus one (32), the
// term division (64) and the variance division (64). The first sample skips
// the variance division, and a dropped sample does not use the unit. The
// request side is stalled from acceptance until the response is committed;
// the response is held in its own register, so a stalled response only
// delays the final update.
module running_mean_variance (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [rmv_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [rmv_pkg::COUNT_BITS-1:0]         rsp_sample_count,
   output logic signed [rmv_pkg::MEAN_BITS-1:0]   rsp_running_mean,
   output logic [rmv_pkg::SUMSQ_BITS-1:0]         rsp_running_variance,
   output logic                                   rsp_overflow_flag
);
   import rmv_pkg::*;

   localparam logic signed [MEAN_BITS+1:0] MEAN_HI = (42'sd1 <<< (MEAN_BITS-1)) - 42'sd1;
   localparam logic signed [MEAN_BITS+1:0] MEAN_LO = -(42'sd1 <<< (MEAN_BITS-1));
   localparam int PAD_MAG = OPND_BITS - MAG_BITS;

   state_type                    state_ff, state_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [MEAN_BITS-1:0]  mean_ff, mean_in;
   logic [SUMSQ_BITS-1:0]        sumsq_ff, sumsq_in;
   logic [SUMSQ_BITS-1:0]        var_ff, var_in;
   logic                         oflag_ff, oflag_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [COUNT_BITS-1:0]        n_ff, n_in;
   logic [MAG_BITS-1:0]          mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic                         flag_ff, flag_in;
   logic signed [MEAN_BITS-1:0]  newmean_ff, newmean_in;
   logic [SUMSQ_BITS-1:0]        sumsq_new_ff, sumsq_new_in;
   logic [SUMSQ_BITS-1:0]        var_new_ff, var_new_in;

   unit_cmd_type                 cmd;
   logic [OPND_BITS-1:0]         opnd_a, opnd_b;
   logic [ACC_BITS-1:0]          acc_init;
   logic                         unit_done;
   logic [ACC_BITS-1:0]          unit_acc;
   logic [OPND_BITS-1:0]         unit_quot;

   logic                         accept;
   logic                         commit;
   logic                         count_full;
   logic signed [MAG_BITS-1:0]   delta;
   logic [MAG_BITS-1:0]          mag_calc;
   logic [COUNT_BITS-1:0]        n_calc;
   logic [COUNT_BITS-1:0]        nm1;
   logic signed [MEAN_BITS+1:0]  mean_sum;
   logic                         sq_ovf;
   logic [SUMSQ_BITS:0]          sum_wide;
   logic [SUMSQ_BITS-1:0]        sumsq_sel;

   rmv_shift_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .opnd_a   (opnd_a),
      .opnd_b   (opnd_b),
      .acc_init (acc_init),
      .done     (unit_done),
      .acc      (unit_acc),
      .quot     (unit_quot)
   );

   always_comb begin
      accept     = req_valid && (state_ff == ST_IDLE);
      commit     = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
      count_full = (count_ff == COUNT_MAX);
      delta      = $signed({req_sample[SAMPLE_BITS-1], req_sample, {FRAC_BITS{1'b0}}})
                 - $signed({mean_ff[MEAN_BITS-1], mean_ff});
      mag_calc   = delta[MAG_BITS-1] ? MAG_BITS'(-delta) : MAG_BITS'(delta);
      n_calc     = count_ff + 1'b1;
      nm1        = n_ff - 1'b1;
      mean_sum   = neg_ff
                 ? $signed({{2{mean_ff[MEAN_BITS-1]}}, mean_ff})
                   - $signed({1'b0, unit_quot[MAG_BITS-1:0]})
                 : $signed({{2{mean_ff[MEAN_BITS-1]}}, mean_ff})
                   + $signed({1'b0, unit_quot[MAG_BITS-1:0]});
      sq_ovf     = (unit_acc[ACC_BITS-1:SUMSQ_BITS+FRAC_BITS] != '0);
      sum_wide   = {1'b0, sumsq_ff} + {1'b0, unit_quot};
      if (state_ff == ST_SQUARE) begin
         sumsq_sel = '1;
      end else begin
         sumsq_sel = sum_wide[SUMSQ_BITS] ? '1 : sum_wide[SUMSQ_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = count_full ? ST_DONE : ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (unit_done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (unit_done) begin
               if (!sq_ovf) begin
                  state_in = ST_SCALE;
               end else begin
                  state_in = (n_ff == COUNT_BITS'(1)) ? ST_DONE : ST_VAR;
               end
            end
         end
         ST_SCALE: begin
            if (unit_done) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            if (unit_done) begin
               state_in = (n_ff == COUNT_BITS'(1)) ? ST_DONE : ST_VAR;
            end
         end
         ST_VAR: begin
            if (unit_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '{start: 1'b0, op: UOP_MUL, steps: '0};
      opnd_a       = '0;
      opnd_b       = '0;
      acc_init     = '0;
      n_in         = n_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      flag_in      = flag_ff;
      newmean_in   = newmean_ff;
      sumsq_new_in = sumsq_new_ff;
      var_new_in   = var_new_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      sumsq_in     = sumsq_ff;
      var_in       = var_ff;
      oflag_in     = oflag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_full) begin
                  n_in         = count_ff;
                  newmean_in   = mean_ff;
                  sumsq_new_in = sumsq_ff;
                  var_new_in   = var_ff;
                  flag_in      = 1'b1;
               end else begin
                  n_in    = n_calc;
                  mag_in  = mag_calc;
                  neg_in  = delta[MAG_BITS-1];
                  flag_in = 1'b0;
                  cmd     = '{start: 1'b1, op: UOP_DIV, steps: STEP_BITS'(MAG_BITS)};
                  opnd_a  = {{(OPND_BITS-COUNT_BITS){1'b0}}, n_calc};
                  opnd_b  = {mag_calc, {PAD_MAG{1'b0}}};
               end
            end
         end
         ST_MEAN: begin
            if (unit_done) begin
               if (mean_sum > MEAN_HI) begin
                  newmean_in = MEAN_HI[MEAN_BITS-1:0];
                  flag_in    = 1'b1;
               end else if (mean_sum < MEAN_LO) begin
                  newmean_in = MEAN_LO[MEAN_BITS-1:0];
                  flag_in    = 1'b1;
               end else begin
                  newmean_in = mean_sum[MEAN_BITS-1:0];
               end
               cmd    = '{start: 1'b1, op: UOP_MUL, steps: STEP_BITS'(MAG_BITS)};
               opnd_a = {{PAD_MAG{1'b0}}, mag_ff};
               opnd_b = {mag_ff, {PAD_MAG{1'b0}}};
            end
         end
         ST_SQUARE, ST_TERM: begin
            if (unit_done) begin
               if (state_ff == ST_SQUARE && !sq_ovf) begin
                  cmd    = '{start: 1'b1, op: UOP_MUL, steps: STEP_BITS'(COUNT_BITS)};
                  opnd_a = unit_acc[SUMSQ_BITS+FRAC_BITS-1:FRAC_BITS];
                  opnd_b = {nm1, {(OPND_BITS-COUNT_BITS){1'b0}}};
               end else begin
                  sumsq_new_in = sumsq_sel;
                  if (state_ff == ST_SQUARE || sum_wide[SUMSQ_BITS]) begin
                     flag_in = 1'b1;
                  end
                  if (n_ff == COUNT_BITS'(1)) begin
                     var_new_in = sumsq_sel;
                  end else begin
                     cmd    = '{start: 1'b1, op: UOP_DIV, steps: STEP_BITS'(SUMSQ_BITS)};
                     opnd_a = {{(OPND_BITS-COUNT_BITS){1'b0}}, nm1};
                     opnd_b = sumsq_sel;
                  end
               end
            end
         end
         ST_SCALE: begin
            if (unit_done) begin
               cmd      = '{start: 1'b1, op: UOP_DIV, steps: STEP_BITS'(OPND_BITS)};
               acc_init = {{(ACC_BITS-COUNT_BITS){1'b0}}, unit_acc[ACC_BITS-1:OPND_BITS]};
               opnd_a   = {{(OPND_BITS-COUNT_BITS){1'b0}}, n_ff};
               opnd_b   = unit_acc[OPND_BITS-1:0];
            end
         end
         ST_VAR: begin
            if (unit_done) begin
               var_new_in = unit_quot;
            end
         end
         ST_DONE: begin
            if (commit) begin
               count_in     = n_ff;
               mean_in      = newmean_ff;
               sumsq_in     = sumsq_new_ff;
               var_in       = var_new_ff;
               oflag_in     = flag_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         sumsq_ff     <= '0;
         var_ff       <= '0;
         oflag_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         sumsq_ff     <= sumsq_in;
         var_ff       <= var_in;
         oflag_ff     <= oflag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      flag_ff      <= flag_in;
      newmean_ff   <= newmean_in;
      sumsq_new_ff <= sumsq_new_in;
      var_new_ff   <= var_new_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sample_count     = count_ff;
   assign rsp_running_mean     = mean_ff;
   assign rsp_running_variance = var_ff;
   assign rsp_overflow_flag    = oflag_ff;

endmodule

### rtl/rmv_shift_unit.sv
module rmv_shift_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  rmv_pkg::unit_cmd_type           cmd,
   input  logic [rmv_pkg::OPND_BITS-1:0]   opnd_a,
   input  logic [rmv_pkg::OPND_BITS-1:0]   opnd_b,
   input  logic [rmv_pkg::ACC_BITS-1:0]    acc_init,
   output logic                            done,
   output logic [rmv_pkg::ACC_BITS-1:0]    acc,
   output logic [rmv_pkg::OPND_BITS-1:0]   quot
);
   import rmv_pkg::*;

   // Multiply runs MSB first over the top bits of B: acc = 2*acc + (bit ? A : 0).
   // Divide is restoring: remainder in the low bits of acc, dividend shifts
   // out of B while the quotient bits shift in at the bottom.

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   unit_op_type           op_ff, op_in;
   logic [STEP_BITS-1:0]  steps_ff, steps_in;
   logic [OPND_BITS-1:0]  a_ff, a_in;
   logic [OPND_BITS-1:0]  b_ff, b_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;

   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS+1:0] diff;
   logic                  fits;
   logic [ACC_BITS-1:0]   mul_sum;

   always_comb begin
      trial   = {acc_ff[COUNT_BITS-1:0], b_ff[OPND_BITS-1]};
      diff    = {1'b0, trial} - {2'b00, a_ff[COUNT_BITS-1:0]};
      fits    = !diff[COUNT_BITS+1];
      mul_sum = {acc_ff[ACC_BITS-2:0], 1'b0}
              + (b_ff[OPND_BITS-1] ? {{COUNT_BITS{1'b0}}, a_ff} : '0);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      steps_in = steps_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         op_in    = cmd.op;
         steps_in = cmd.steps;
         a_in     = opnd_a;
         b_in     = opnd_b;
         acc_in   = acc_init;
      end else if (busy_ff) begin
         case (op_ff)
            UOP_MUL: begin
               acc_in = mul_sum;
               b_in   = {b_ff[OPND_BITS-2:0], 1'b0};
            end
            UOP_DIV: begin
               acc_in = {{(ACC_BITS-COUNT_BITS){1'b0}},
                         (fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0])};
               b_in   = {b_ff[OPND_BITS-2:0], fits};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      steps_ff <= steps_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quot = b_ff;

endmodule

### rtl/rmv_checker.sv
module rmv_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [rmv_pkg::COUNT_BITS-1:0]         rsp_sample_count,
   input logic [rmv_pkg::SUMSQ_BITS-1:0]         rsp_running_variance,
   input logic                                   rsp_overflow_flag
);
   import rmv_pkg::*;

   // A stalled response beat holds its sample count and variance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_count)
         && $stable(rsp_running_variance))
      else $error("stalled response beat changed");

   // The block works on one sample at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a sample is in progress");

   // Every response follows at least one sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count != '0)
      else $error("response with zero sample count");

   // A single sample has no spread.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_count == COUNT_BITS'(1) && !rsp_overflow_flag
         |-> rsp_running_variance == '0)
      else $error("nonzero variance after the first sample");

endmodule

bind running_mean_variance rmv_checker u_rmv_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_sample_count     (rsp_sample_count),
   .rsp_running_variance (rsp_running_variance),
   .rsp_overflow_flag    (rsp_overflow_flag)
);

### verif/running_mean_variance_tb.sv
module running_mean_variance_tb;
   import rmv_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int PHASE_ITEMS    = 370;
   localparam int DIR_ROWS       = 15;

   localparam logic signed [63:0] MEAN_CEIL   = 64'sd549755813887;
   localparam logic signed [63:0] MEAN_FLOOR  = -64'sd549755813888;
   localparam logic signed [63:0] SAMPLE_CEIL = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SAMPLE_FLOOR = -(64'sd1 <<< (SAMPLE_BITS - 1));

   typedef struct packed {
      logic [COUNT_BITS-1:0]       count;
      logic signed [MEAN_BITS-1:0] mean;
      logic [SUMSQ_BITS-1:0]       variance;
      logic                        flag;
   } stats_beat_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          known;
      stats_beat_type                want;
   } dir_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [COUNT_BITS-1:0]         rsp_sample_count;
   logic signed [MEAN_BITS-1:0]   rsp_running_mean;
   logic [SUMSQ_BITS-1:0]         rsp_running_variance;
   logic                          rsp_overflow_flag;

   int idle_pct = 0;
   int stall_pct = 0;
   int fail_count = 0;
   int quiet_cycles = 0;

   logic [COUNT_BITS-1:0]       st_count = '0;
   logic signed [MEAN_BITS-1:0] st_mean = '0;
   logic [SUMSQ_BITS-1:0]       st_sumsq = '0;
   logic [SUMSQ_BITS-1:0]       st_variance = '0;

   stats_beat_type pending_stats[$];

   dir_row_type directed_rows [DIR_ROWS] = '{
      '{24'sh800000, 1'b1, '{32'd1, 40'sh80_0000_0000, 64'd0, 1'b0}},
      '{24'sh7FFFFF, 1'b1, '{32'd2, -40'sd32768, 64'h7FFF_FF00_0000_8000, 1'b0}},
      '{24'sd0, 1'b0, '0},
      '{-24'sd1, 1'b0, '0},
      '{24'sd1, 1'b0, '0},
      '{24'sh555555, 1'b0, '0},
      '{24'shAAAAAA, 1'b0, '0},
      '{24'sd0, 1'b0, '0},
      '{24'sd0, 1'b0, '0},
      '{24'sd0, 1'b0, '0},
      '{24'sd1, 1'b0, '0},
      '{24'sd2, 1'b0, '0},
      '{-24'sd2, 1'b0, '0},
      '{24'sd100, 1'b0, '0},
      '{-24'sd100, 1'b0, '0}
   };

   running_mean_variance DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_running_mean     (rsp_running_mean),
      .rsp_running_variance (rsp_running_variance),
      .rsp_overflow_flag    (rsp_overflow_flag)
   );

   always #5 clock = ~clock;

   task automatic update_stats(input logic signed [SAMPLE_BITS-1:0] s,
                               output stats_beat_type r);
      logic signed [63:0] sx;
      logic signed [63:0] mx;
      logic signed [63:0] delta;
      logic signed [63:0] new_mean;
      logic [63:0]        mag;
      logic [63:0]        n;
      logic [63:0]        qm;
      logic [127:0]       sq;
      logic [127:0]       q;
      logic [127:0]       term;
      logic [64:0]        sum;
      logic               sat;
      sat = 1'b0;
      if (st_count == COUNT_MAX) begin
         sat = 1'b1;
      end else begin
         sx = s;
         mx = st_mean;
         n = {32'd0, st_count} + 64'd1;
         delta = sx * 64'sd65536 - mx;
         mag = (delta < 0) ? -delta : delta;
         qm = mag / n;
         new_mean = (delta < 0) ? mx - $signed(qm) : mx + $signed(qm);
         if (new_mean > MEAN_CEIL) begin
            new_mean = MEAN_CEIL;
            sat = 1'b1;
         end
         if (new_mean < MEAN_FLOOR) begin
            new_mean = MEAN_FLOOR;
            sat = 1'b1;
         end
         sq = {64'd0, mag} * {64'd0, mag};
         q = sq >> 16;
         term = '0;
         if (q[127:64] != 0) begin
            sat = 1'b1;
         end else begin
            term = (q * {64'd0, n - 64'd1}) / {64'd0, n};
            if (term[127:64] != 0) sat = 1'b1;
         end
         if (sat && (q[127:64] != 0 || term[127:64] != 0)) begin
            st_sumsq = '1;
         end else begin
            sum = {1'b0, st_sumsq} + {1'b0, term[63:0]};
            if (sum[64]) begin
               st_sumsq = '1;
               sat = 1'b1;
            end else begin
               st_sumsq = sum[63:0];
            end
         end
         st_count = n[COUNT_BITS-1:0];
         st_mean = new_mean[MEAN_BITS-1:0];
         st_variance = (n == 64'd1) ? st_sumsq : st_sumsq / (n - 64'd1);
      end
      r.count = st_count;
      r.mean = st_mean;
      r.variance = st_variance;
      r.flag = sat;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic known,
                              input stats_beat_type typed);
      stats_beat_type predicted;
      if ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < idle_pct) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_stats(s, predicted);
      pending_stats.push_back(known ? typed : predicted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   always @(posedge clock) begin
      stats_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_stats.size() == 0) begin
            $error("response beat with no expectation pending");
            fail_count++;
         end else begin
            want = pending_stats.pop_front();
            if (rsp_sample_count !== want.count) begin
               $error("sample_count expected %0d got %0d", want.count, rsp_sample_count);
               fail_count++;
            end
            if (rsp_running_mean !== want.mean) begin
               $error("running_mean expected %0d got %0d", want.mean, rsp_running_mean);
               fail_count++;
            end
            if (rsp_running_variance !== want.variance) begin
               $error("running_variance expected %0d got %0d", want.variance,
                      rsp_running_variance);
               fail_count++;
            end
            if (rsp_overflow_flag !== want.flag) begin
               $error("overflow_flag expected %0d got %0d", want.flag, rsp_overflow_flag);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("running_mean_variance regression: fail");
            $finish;
         end
      end
   end

   initial begin
      stats_beat_type     none;
      logic signed [63:0] v;
      logic [31:0]        raw;
      int                 w;
      none = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].sample, directed_rows[i].known, directed_rows[i].want);
      end
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 54;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 54;
            end
            default: begin
               idle_pct = 22;
               stall_pct <= 22;
            end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            raw = $urandom;
            // Most samples stay close to the running mean so that the sum of squares
            // keeps its headroom; full-range outliers in the last phase drive it to
            // saturation.
            if (p == 3 && $urandom_range(3, 0) == 0) begin
               v = $signed(raw[SAMPLE_BITS-1:0]);
            end else begin
               w = $urandom_range(16, 0);
               v = raw & ((32'd1 << w) - 32'd1);
               if ($urandom_range(1, 0) == 1) v = -v;
               v = v + (st_mean >>> 16);
               if (v > SAMPLE_CEIL) v = SAMPLE_CEIL;
               if (v < SAMPLE_FLOOR) v = SAMPLE_FLOOR;
            end
            send_sample(v[SAMPLE_BITS-1:0], 1'b0, none);
         end
      end
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("running_mean_variance regression: pass");
      end else begin
         $display("running_mean_variance regression: fail");
      end
      $finish;
   end

endmodule
